[design/ogt_pkg.sv]
// Package for the oscillation gain tuner: shared types, command and register codes,
// sequencer states and the control word that the sequencer drives.
// No dependencies; every other design file refers to it by scoped names.
package ogt_pkg;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 32;
  localparam int STEP_W      = 16;
  localparam int LIM_W       = 15;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 104;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_CLIMB   = 2'd2,
    CMD_RESTART = 2'd3
  } ogt_cmd_t;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_KP_START  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KI_VALUE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_START  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KP_STEP   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_STEP   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CALM_MIN  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CALM_MAX  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_OSC_LIMIT = 3'd7;

  // Gyro axes, in the order the spread unit walks them
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Threshold slots held by the spread unit
  localparam logic [1:0] LIM_CALM_MIN = 2'd0;
  localparam logic [1:0] LIM_CALM_MAX = 2'd1;
  localparam logic [1:0] LIM_OSC      = 2'd2;

  // Threshold squaring takes two multiplier passes per limit plus one drain step
  localparam int LIM_LAST = 6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIM,
    ST_SQ,
    ST_SS,
    ST_VAR,
    ST_MM,
    ST_DEC,
    ST_OUT
  } ogt_state_t;

  // Control word from the sequencer to the datapath
  typedef struct packed {
    ogt_state_t  st;
    logic        first;
    logic        odd;
    logic [1:0]  lim_sel;
    logic        lim_wr;
    logic [1:0]  lim_wr_idx;
    logic [1:0]  axis;
  } ogt_ctl_t;

  // Events seen by the sequencer
  typedef struct packed {
    logic     fire;
    ogt_cmd_t cmd;
    logic     tick_ok;
    logic     out_free;
  } ogt_evt_t;

  // Outcome of the spread test
  typedef struct packed {
    logic calm;
    logic osc;
  } ogt_verdict_t;

  // Phase flags
  typedef struct packed {
    logic settled;
    logic osc;
    logic stable1;
  } ogt_phase_t;

  // One gyro sample, three axes
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] z;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] x;
  } ogt_sample_t;

endpackage

[design/oscillation_gain_tuner_unit.sv]
// Top level of the oscillation gain tuner: configuration registers, gain and phase
// state, input handshake and result register. Instantiates ogt_window, ogt_spread
// and ogt_seq; depends on ogt_pkg.
//
// Usage. Items arrive on the in_ stream; in_tuser says what each item is (gyro
// sample, tuning tick, climb command or restart). Samples fill a WINDOW_LEN deep
// window per axis; a tick with a refreshed window while climbing evaluates the
// spread of each axis, steps the phase flags and raises kp or kd by their steps,
// saturating at the 32-bit maximum. A restart reloads the gains from their start
// registers, clears the phase flags and reports at once.
// Flow. Samples and climb commands are taken back to back while the block is idle;
// a tick that is not acted on also leaves it idle. A restart enters the reporting
// step and loads the result register once the result slot is free. An evaluating
// tick holds in_tready low while the sequencer squares the three thresholds, then
// passes each axis through the one multiplier, then takes the decision step and
// loads the result register.
// Results wait in a single output register; while out_tready is low a finished
// result holds and the block stays busy until the result slot frees.
// Reset (rst_n low, synchronous) restores registers to their defaults, gains to
// 1000/0/0, clears the phase flags, fill count, fresh and climb state. The window
// contents are not cleared; a tick acts only after the window has refilled.
module oscillation_gain_tuner_unit #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: sample_x[15:0], sample_y[31:16], sample_z[47:32], climbing[48], zero fill
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ogt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]                         in_tuser,
  // out_tdata: kp_gain[31:0], ki_gain[63:32], kd_gain[95:64], first_stable[96],
  // oscillating[97], settled_again[98], zero fill
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ogt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [ogt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ogt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int GW     = ogt_pkg::GAIN_W;

  // Saturating gain increment
  function automatic logic [GW-1:0] sat_add(input logic [GW-1:0] a,
                                            input logic [ogt_pkg::STEP_W-1:0] b);
    logic [GW:0] s;
    s = {1'b0, a} + {{(GW + 1 - ogt_pkg::STEP_W){1'b0}}, b};
    return s[GW] ? ogt_pkg::GAIN_MAX : s[GW-1:0];
  endfunction

  // Configuration registers
  logic [GW-1:0]               kp_start_r;
  logic [GW-1:0]               ki_value_r;
  logic [GW-1:0]               kd_start_r;
  logic [ogt_pkg::STEP_W-1:0]  kp_step_r;
  logic [ogt_pkg::STEP_W-1:0]  kd_step_r;
  logic [ogt_pkg::LIM_W-1:0]   calm_min_r;
  logic [ogt_pkg::LIM_W-1:0]   calm_max_r;
  logic [ogt_pkg::LIM_W-1:0]   osc_limit_r;

  // Tuning state
  logic [FILL_W-1:0]           fill_r;
  logic                        fresh_r;
  logic                        fresh_nxt;
  logic                        climb_r;
  logic                        climb_nxt;
  ogt_pkg::ogt_phase_t         phase_r;
  ogt_pkg::ogt_phase_t         phase_nxt;
  ogt_pkg::ogt_phase_t         phase_dec;
  logic [GW-1:0]               gain_p_r;
  logic [GW-1:0]               gain_p_nxt;
  logic [GW-1:0]               gain_i_r;
  logic [GW-1:0]               gain_i_nxt;
  logic [GW-1:0]               gain_d_r;
  logic [GW-1:0]               gain_d_nxt;

  // Result register
  logic                        out_valid_r;
  logic [GW-1:0]               out_kp_r;
  logic [GW-1:0]               out_ki_r;
  logic [GW-1:0]               out_kd_r;
  ogt_pkg::ogt_phase_t         out_phase_r;

  // Handshake and internal links
  logic                        in_fire;
  ogt_pkg::ogt_cmd_t           cmd;
  ogt_pkg::ogt_sample_t        sample;
  logic                        climbing;
  logic                        sample_fire;
  logic                        restart_fire;
  logic                        tick_ok;
  logic                        out_free;
  logic                        out_load;
  logic                        seq_ready;
  ogt_pkg::ogt_ctl_t           ctl;
  ogt_pkg::ogt_evt_t           evt;
  ogt_pkg::ogt_verdict_t       verdict;
  logic signed [ogt_pkg::SAMPLE_W-1:0] tap;

  // Input field unpacking
  assign cmd      = ogt_pkg::ogt_cmd_t'(in_tuser);
  assign sample.x = in_tdata[15:0];
  assign sample.y = in_tdata[31:16];
  assign sample.z = in_tdata[47:32];
  assign climbing = in_tdata[48];

  assign in_tready    = seq_ready;
  assign in_fire      = in_tvalid && seq_ready;
  assign sample_fire  = in_fire && (cmd == ogt_pkg::CMD_SAMPLE);
  assign restart_fire = in_fire && (cmd == ogt_pkg::CMD_RESTART);
  assign tick_ok      = fresh_r && climb_r;
  assign out_free     = !out_valid_r || out_tready;
  assign out_load     = (ctl.st == ogt_pkg::ST_OUT) && out_free;

  always_comb begin
    evt.fire     = in_fire;
    evt.cmd      = cmd;
    evt.tick_ok  = tick_ok;
    evt.out_free = out_free;
  end

  ogt_seq #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .ready (seq_ready),
    .ctl   (ctl)
  );

  ogt_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk    (clk),
    .push   (sample_fire),
    .sample (sample),
    .ctl    (ctl),
    .tap    (tap)
  );

  ogt_spread #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_spread (
    .clk               (clk),
    .ctl               (ctl),
    .tap               (tap),
    .calm_min_limit    (calm_min_r),
    .calm_max_limit    (calm_max_r),
    .oscillation_limit (osc_limit_r),
    .verdict           (verdict)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_start_r  <= GW'(1000);
      ki_value_r  <= '0;
      kd_start_r  <= '0;
      kp_step_r   <= ogt_pkg::STEP_W'(2000);
      kd_step_r   <= ogt_pkg::STEP_W'(20);
      calm_min_r  <= ogt_pkg::LIM_W'(80);
      calm_max_r  <= ogt_pkg::LIM_W'(160);
      osc_limit_r <= ogt_pkg::LIM_W'(1040);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        ogt_pkg::REG_KP_START:  kp_start_r  <= cfg_wdata;
        ogt_pkg::REG_KI_VALUE:  ki_value_r  <= cfg_wdata;
        ogt_pkg::REG_KD_START:  kd_start_r  <= cfg_wdata;
        ogt_pkg::REG_KP_STEP:   kp_step_r   <= cfg_wdata[ogt_pkg::STEP_W-1:0];
        ogt_pkg::REG_KD_STEP:   kd_step_r   <= cfg_wdata[ogt_pkg::STEP_W-1:0];
        ogt_pkg::REG_CALM_MIN:  calm_min_r  <= cfg_wdata[ogt_pkg::LIM_W-1:0];
        ogt_pkg::REG_CALM_MAX:  calm_max_r  <= cfg_wdata[ogt_pkg::LIM_W-1:0];
        ogt_pkg::REG_OSC_LIMIT: osc_limit_r <= cfg_wdata[ogt_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase step for an evaluating tick
  always_comb begin
    phase_dec = phase_r;
    if (!phase_r.stable1 && verdict.calm) begin
      phase_dec.stable1 = 1'b1;
    end else if (phase_r.stable1 && verdict.osc) begin
      phase_dec.osc = 1'b1;
    end else if (phase_r.stable1 && phase_r.osc && verdict.calm) begin
      phase_dec.settled = 1'b1;
    end
  end

  // Next values of the window bookkeeping, climb flag, phase and gains
  always_comb begin
    fresh_nxt  = fresh_r;
    climb_nxt  = climb_r;
    phase_nxt  = phase_r;
    gain_p_nxt = gain_p_r;
    gain_i_nxt = gain_i_r;
    gain_d_nxt = gain_d_r;
    if (in_fire) begin
      case (cmd)
        ogt_pkg::CMD_SAMPLE: begin
          if (fill_r == FILL_W'(WINDOW_LEN)) fresh_nxt = 1'b1;
        end
        ogt_pkg::CMD_TICK: begin
          if (tick_ok) fresh_nxt = 1'b0;
        end
        ogt_pkg::CMD_CLIMB: climb_nxt = climbing;
        ogt_pkg::CMD_RESTART: begin
          gain_p_nxt = kp_start_r;
          gain_i_nxt = ki_value_r;
          gain_d_nxt = kd_start_r;
          phase_nxt  = '0;
        end
        default: ;
      endcase
    end else if (ctl.st == ogt_pkg::ST_DEC) begin
      phase_nxt = phase_dec;
      if (!phase_dec.stable1 || !phase_dec.osc) begin
        gain_p_nxt = sat_add(gain_p_r, kp_step_r);
      end else if (!phase_dec.settled) begin
        gain_d_nxt = sat_add(gain_d_r, kd_step_r);
      end
    end
  end

  // Tuning state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      fresh_r  <= 1'b0;
      climb_r  <= 1'b0;
      phase_r  <= '0;
      gain_p_r <= GW'(1000);
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else begin
      if (sample_fire && (fill_r != FILL_W'(WINDOW_LEN))) fill_r <= fill_r + 1'b1;
      fresh_r  <= fresh_nxt;
      climb_r  <= climb_nxt;
      phase_r  <= phase_nxt;
      gain_p_r <= gain_p_nxt;
      gain_i_r <= gain_i_nxt;
      gain_d_r <= gain_d_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kp_r    <= gain_p_r;
      out_ki_r    <= gain_i_r;
      out_kd_r    <= gain_d_r;
      out_phase_r <= phase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_phase_r.settled, out_phase_r.osc, out_phase_r.stable1,
                       out_kd_r, out_ki_r, out_kp_r};

endmodule

[design/ogt_window.sv]
// Three-axis sliding window of gyro samples, built as shift lines.
// During evaluation the selected axis rotates once round so that its oldest tap
// presents every sample in turn. Depends on ogt_pkg.
module ogt_window #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                                clk,
  input  logic                                push,
  input  ogt_pkg::ogt_sample_t                sample,
  input  ogt_pkg::ogt_ctl_t                   ctl,
  output logic signed [ogt_pkg::SAMPLE_W-1:0] tap
);

  logic signed [ogt_pkg::SAMPLE_W-1:0] win_x_r [WINDOW_LEN];
  logic signed [ogt_pkg::SAMPLE_W-1:0] win_y_r [WINDOW_LEN];
  logic signed [ogt_pkg::SAMPLE_W-1:0] win_z_r [WINDOW_LEN];

  logic rot_x;
  logic rot_y;
  logic rot_z;

  // Rotation applies only to the axis under evaluation
  always_comb begin
    rot_x = (ctl.st == ogt_pkg::ST_SQ) && (ctl.axis == ogt_pkg::AXIS_X);
    rot_y = (ctl.st == ogt_pkg::ST_SQ) && (ctl.axis == ogt_pkg::AXIS_Y);
    rot_z = (ctl.st == ogt_pkg::ST_SQ) && (ctl.axis == ogt_pkg::AXIS_Z);
  end

  // Shift a new sample in at the young end, or rotate the oldest back round
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_x_r[i] <= win_x_r[i+1];
        win_y_r[i] <= win_y_r[i+1];
        win_z_r[i] <= win_z_r[i+1];
      end
      win_x_r[WINDOW_LEN-1] <= sample.x;
      win_y_r[WINDOW_LEN-1] <= sample.y;
      win_z_r[WINDOW_LEN-1] <= sample.z;
    end else begin
      if (rot_x) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_x_r[i] <= win_x_r[i+1];
        end
        win_x_r[WINDOW_LEN-1] <= win_x_r[0];
      end
      if (rot_y) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_y_r[i] <= win_y_r[i+1];
        end
        win_y_r[WINDOW_LEN-1] <= win_y_r[0];
      end
      if (rot_z) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_z_r[i] <= win_z_r[i+1];
        end
        win_z_r[WINDOW_LEN-1] <= win_z_r[0];
      end
    end
  end

  // Oldest tap of the selected axis
  always_comb begin
    case (ctl.axis)
      ogt_pkg::AXIS_X: tap = win_x_r[0];
      ogt_pkg::AXIS_Y: tap = win_y_r[0];
      ogt_pkg::AXIS_Z: tap = win_z_r[0];
      default:         tap = win_x_r[0];
    endcase
  end

endmodule

[design/ogt_spread.sv]
// Spread unit: one shared signed multiplier with accumulators that forms
// V = N*sum(x^2) - (sum x)^2 per axis, keeps the smallest and largest V and the
// squared thresholds (N*L)^2, and compares them. Depends on ogt_pkg.
module ogt_spread #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                                clk,
  input  ogt_pkg::ogt_ctl_t                   ctl,
  input  logic signed [ogt_pkg::SAMPLE_W-1:0] tap,
  input  logic [ogt_pkg::LIM_W-1:0]           calm_min_limit,
  input  logic [ogt_pkg::LIM_W-1:0]           calm_max_limit,
  input  logic [ogt_pkg::LIM_W-1:0]           oscillation_limit,
  output ogt_pkg::ogt_verdict_t               verdict
);

  localparam int CLOG_N = $clog2(WINDOW_LEN);
  localparam int SUM_W  = ogt_pkg::SAMPLE_W + CLOG_N;
  localparam int PROD_W = 2 * SUM_W;
  localparam int Q_W    = 2 * ogt_pkg::SAMPLE_W - 1 + CLOG_N;

  logic signed [SUM_W-1:0]  mul_a;
  logic signed [SUM_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SUM_W-1:0]  tap_ext;
  logic signed [SUM_W-1:0]  lim_ext;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [Q_W-1:0]           q_r;
  logic [PROD_W-1:0]        v_r;
  logic [PROD_W-1:0]        vmin_r;
  logic [PROD_W-1:0]        vmax_r;
  logic [PROD_W-1:0]        limsq_r [3];

  assign tap_ext = {{(SUM_W - ogt_pkg::SAMPLE_W){tap[ogt_pkg::SAMPLE_W-1]}}, tap};

  // Threshold chosen for the current squaring pass
  always_comb begin
    case (ctl.lim_sel)
      ogt_pkg::LIM_CALM_MIN:
        lim_ext = {{(SUM_W - ogt_pkg::LIM_W){1'b0}}, calm_min_limit};
      ogt_pkg::LIM_CALM_MAX:
        lim_ext = {{(SUM_W - ogt_pkg::LIM_W){1'b0}}, calm_max_limit};
      ogt_pkg::LIM_OSC:
        lim_ext = {{(SUM_W - ogt_pkg::LIM_W){1'b0}}, oscillation_limit};
      default:
        lim_ext = '0;
    endcase
  end

  // Operand selection for the shared multiplier
  always_comb begin
    case (ctl.st)
      ogt_pkg::ST_LIM: begin
        if (ctl.odd) begin
          mul_a = prod_r[SUM_W-1:0];
          mul_b = prod_r[SUM_W-1:0];
        end else begin
          mul_a = lim_ext;
          mul_b = SUM_W'(WINDOW_LEN);
        end
      end
      ogt_pkg::ST_SQ: begin
        mul_a = tap_ext;
        mul_b = tap_ext;
      end
      ogt_pkg::ST_SS: begin
        mul_a = sum_r;
        mul_b = sum_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Product register and accumulators; the square of a sample passes through the
  // product register before it is added
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (ctl.st)
      ogt_pkg::ST_LIM: begin
        if (ctl.lim_wr) begin
          limsq_r[ctl.lim_wr_idx] <= $unsigned(prod_r);
        end
      end
      ogt_pkg::ST_SQ: begin
        sum_r <= (ctl.first ? '0 : sum_r) + tap_ext;
        q_r   <= ctl.first ? '0 : (q_r + prod_r[Q_W-1:0]);
      end
      ogt_pkg::ST_SS: begin
        q_r <= q_r + prod_r[Q_W-1:0];
      end
      ogt_pkg::ST_VAR: begin
        v_r <= PROD_W'(q_r) * PROD_W'(WINDOW_LEN) - $unsigned(prod_r);
      end
      ogt_pkg::ST_MM: begin
        if (ctl.axis == ogt_pkg::AXIS_X) begin
          vmin_r <= v_r;
          vmax_r <= v_r;
        end else begin
          if (v_r < vmin_r) vmin_r <= v_r;
          if (v_r > vmax_r) vmax_r <= v_r;
        end
      end
      default: ;
    endcase
  end

  // Threshold tests on the squared spreads
  always_comb begin
    verdict.calm = (vmin_r < limsq_r[ogt_pkg::LIM_CALM_MIN]) &&
                   (vmax_r < limsq_r[ogt_pkg::LIM_CALM_MAX]);
    verdict.osc  = vmax_r > limsq_r[ogt_pkg::LIM_OSC];
  end

endmodule

[design/ogt_seq.sv]
// Sequencer for the oscillation gain tuner: walks threshold squaring, the per-axis
// sample passes and the decision step, and drives the datapath control word.
// Depends on ogt_pkg.
module ogt_seq #(
  parameter int WINDOW_LEN = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ogt_pkg::ogt_evt_t evt,
  output logic              ready,
  output ogt_pkg::ogt_ctl_t ctl
);

  localparam int CLOG_N = $clog2(WINDOW_LEN);
  localparam int CNT_W  = (CLOG_N > 3) ? CLOG_N : 3;

  ogt_pkg::ogt_state_t state_r;
  ogt_pkg::ogt_state_t state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [1:0]          axis_r;
  logic [1:0]          axis_nxt;

  // State, step counter and axis registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ogt_pkg::ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= ogt_pkg::AXIS_X;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    case (state_r)
      ogt_pkg::ST_IDLE: begin
        if (evt.fire) begin
          case (evt.cmd)
            ogt_pkg::CMD_TICK: begin
              if (evt.tick_ok) begin
                state_nxt = ogt_pkg::ST_LIM;
                cnt_nxt   = '0;
                axis_nxt  = ogt_pkg::AXIS_X;
              end
            end
            ogt_pkg::CMD_RESTART: state_nxt = ogt_pkg::ST_OUT;
            default: ;
          endcase
        end
      end
      ogt_pkg::ST_LIM: begin
        if (cnt_r == CNT_W'(ogt_pkg::LIM_LAST)) begin
          state_nxt = ogt_pkg::ST_SQ;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ogt_pkg::ST_SQ: begin
        if (cnt_r == CNT_W'(WINDOW_LEN - 1)) begin
          state_nxt = ogt_pkg::ST_SS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ogt_pkg::ST_SS:  state_nxt = ogt_pkg::ST_VAR;
      ogt_pkg::ST_VAR: state_nxt = ogt_pkg::ST_MM;
      ogt_pkg::ST_MM: begin
        if (axis_r == ogt_pkg::AXIS_Z) begin
          state_nxt = ogt_pkg::ST_DEC;
        end else begin
          state_nxt = ogt_pkg::ST_SQ;
          cnt_nxt   = '0;
          axis_nxt  = axis_r + 1'b1;
        end
      end
      ogt_pkg::ST_DEC: state_nxt = ogt_pkg::ST_OUT;
      ogt_pkg::ST_OUT: begin
        if (evt.out_free) state_nxt = ogt_pkg::ST_IDLE;
      end
      default: state_nxt = ogt_pkg::ST_IDLE;
    endcase

    ready          = (state_r == ogt_pkg::ST_IDLE);
    ctl.st         = state_r;
    ctl.first      = (cnt_r == '0);
    ctl.odd        = cnt_r[0];
    ctl.lim_sel    = cnt_r[2:1];
    ctl.lim_wr     = (state_r == ogt_pkg::ST_LIM) && (cnt_r != '0) && !cnt_r[0];
    ctl.lim_wr_idx = cnt_r[2:1] - 2'd1;
    ctl.axis       = axis_r;
  end

endmodule

[design/ogt_checker.sv]
// Port-level checks for the oscillation gain tuner, bound to its top level.
// Depends on ogt_pkg and oscillation_gain_tuner_unit.
module ogt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [1:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ogt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  // A restart item always makes the block busy while it reports
  a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ogt_pkg::CMD_RESTART) |=> !in_tready)
    else $error("restart item did not enter the reporting step");

  // Samples and climb commands do not stall the input
  a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    ((in_tuser == ogt_pkg::CMD_SAMPLE) || (in_tuser == ogt_pkg::CMD_CLIMB))
    |=> in_tready)
    else $error("sample or climb item stalled the input");

  // A new result is only loaded from the busy reporting step
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while the block was idle");

endmodule

bind oscillation_gain_tuner_unit ogt_checker u_ogt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
